// ===== rtl/pic_pkg.sv =====
`default_nettype none

package pic_pkg;

   localparam int CB_W    = 8;  // control byte width
   localparam int LVL_W   = 3;  // priority level width
   localparam int SRC_W   = 6;  // source index width
   localparam int BE_W    = 6;  // both-edge select register width
   localparam int REQ_BIT = 3;
   localparam int POL_BIT = 4;
   localparam int LVS_BIT = 5;

   localparam logic [CB_W-1:0] REQ_MASK = CB_W'(1) << REQ_BIT;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_ACK   = 2'd2,
      CMD_LINE  = 2'd3
   } cmd_type;

   // command as broadcast to every source cell
   typedef struct packed {
      cmd_type         cmd;
      logic [CB_W-1:0] wdata;
      logic            line_level;
   } op_type;

   // posting level of a source and its index, also the winner of the tree
   typedef struct packed {
      logic [LVL_W-1:0] lvl;
      logic [SRC_W-1:0] idx;
   } post_type;

endpackage

`default_nettype wire

// ===== rtl/pic_cell.sv =====
`default_nettype none

module pic_cell #(
   parameter bit IS_EXT = 1'b0
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      sel,
   input  wire pic_pkg::op_type           op,
   input  wire logic                      both_edge,
   output logic [pic_pkg::CB_W-1:0]       cb
);

   logic [pic_pkg::CB_W-1:0] cb_ff, cb_in;
   logic                     line_ff, line_in;

   always_comb begin
      cb_in   = cb_ff;
      line_in = line_ff;
      if (sel) begin
         unique case (op.cmd)
            pic_pkg::CMD_READ: begin
               cb_in = cb_ff;
            end
            pic_pkg::CMD_WRITE: begin
               // a write itself can only clear the request; level sense below may resample it
               cb_in = (cb_ff & op.wdata & pic_pkg::REQ_MASK) |
                       (op.wdata & ~pic_pkg::REQ_MASK);
               if (IS_EXT && op.wdata[pic_pkg::LVS_BIT]) begin
                  cb_in[pic_pkg::REQ_BIT] = (line_ff == op.wdata[pic_pkg::POL_BIT]);
               end
            end
            pic_pkg::CMD_ACK: begin
               cb_in[pic_pkg::REQ_BIT] = 1'b0;
            end
            pic_pkg::CMD_LINE: begin
               line_in = op.line_level;
               if (!IS_EXT) begin
                  // falling edge
                  if (line_ff && !op.line_level) begin
                     cb_in[pic_pkg::REQ_BIT] = 1'b1;
                  end
               end else if (cb_ff[pic_pkg::LVS_BIT]) begin
                  cb_in[pic_pkg::REQ_BIT] = (op.line_level == cb_ff[pic_pkg::POL_BIT]);
               end else if ((line_ff != op.line_level) && !cb_ff[pic_pkg::REQ_BIT] &&
                            (both_edge || (op.line_level == cb_ff[pic_pkg::POL_BIT]))) begin
                  cb_in[pic_pkg::REQ_BIT] = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cb_ff   <= '0;
         line_ff <= 1'b1;
      end else begin
         cb_ff   <= cb_in;
         line_ff <= line_in;
      end
   end

   assign cb = cb_ff;

endmodule

`default_nettype wire

// ===== rtl/pic_prio.sv =====
`default_nettype none

module pic_prio #(
   parameter int SOURCES = 64
) (
   input  wire pic_pkg::post_type leaf [SOURCES],
   output pic_pkg::post_type      win
);

   localparam int LEAVES = 1 << $clog2(SOURCES);

   // heap layout: node n has children 2n and 2n+1, leaves start at LEAVES
   pic_pkg::post_type node [1:2*LEAVES-1];

   genvar n;
   generate
      for (n = 0; n < LEAVES; n++) begin : g_leaf
         if (n < SOURCES) begin : g_used
            assign node[LEAVES+n] = leaf[n];
         end else begin : g_pad
            assign node[LEAVES+n] = '0;
         end
      end
      for (n = 1; n < LEAVES; n++) begin : g_node
         // left side holds the lower indices, so it wins ties
         assign node[n] = (node[2*n].lvl >= node[2*n+1].lvl) ? node[2*n] : node[2*n+1];
      end
   endgenerate

   always_comb begin
      win = node[1];
      if (node[1].lvl == '0) begin
         win.idx = '0;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/priority_interrupt_controller.sv =====
`default_nettype none

// level-priority interrupt controller with one control byte per source
//
// request channel (req_*): one command per transfer - read or write a control
// byte, acknowledge a source, or report a new level on a source's line
// response channel (rsp_*): exactly one transfer per command, in order; it
// carries the control byte for a read (else zero) and the highest pending
// level with its source index as it stands after that command
// csr port: csr_write_enable loads the both-edge select bits of the
// external lines; write it only while no command is in flight
//
// a command passes through the middle stage into the response register: the
// source cells update at the request transfer, the 64-way priority tree runs
// while the command waits in the middle stage. one command per cycle is
// sustained while the response side keeps up
// a stalled response holds; one more command is taken into the middle stage
// and req_stall rises only when both stages are full
// reset clears all control bytes, sets every stored line high, clears the
// both-edge bits and empties the pipeline

module priority_interrupt_controller #(
   parameter int SOURCES   = 64,
   parameter int EXT_LINES = 6
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_enable,
   input  wire logic [pic_pkg::BE_W-1:0]       csr_write_data,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [1:0]                     req_cmd,
   input  wire logic [pic_pkg::SRC_W-1:0]      req_src_index,
   input  wire logic [pic_pkg::CB_W-1:0]       req_wdata,
   input  wire logic                           req_line_level,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [pic_pkg::CB_W-1:0]            rsp_read_data,
   output logic                                rsp_irq_pending,
   output logic [pic_pkg::LVL_W-1:0]           rsp_irq_level,
   output logic [pic_pkg::SRC_W-1:0]           rsp_irq_number
);

   logic                        req_accept;
   logic                        out_load;
   pic_pkg::op_type             op;
   logic [pic_pkg::CB_W-1:0]    cb     [SOURCES];
   pic_pkg::post_type           post   [SOURCES];
   pic_pkg::post_type           win;
   logic [pic_pkg::CB_W-1:0]    rd_byte;

   logic [pic_pkg::BE_W-1:0]    both_edge_ff, both_edge_in;
   logic                        mid_valid_ff, mid_valid_in;
   logic [pic_pkg::CB_W-1:0]    mid_rd_ff, mid_rd_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [pic_pkg::CB_W-1:0]    rsp_rd_ff, rsp_rd_in;
   pic_pkg::post_type           rsp_win_ff, rsp_win_in;

   // handshake: output register loads when empty or draining
   assign out_load   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = mid_valid_ff && !out_load;
   assign req_accept = req_valid && !req_stall;

   assign op.cmd        = pic_pkg::cmd_type'(req_cmd);
   assign op.wdata      = req_wdata;
   assign op.line_level = req_line_level;

   // one cell per source; the addressed cell updates at the request transfer
   genvar i;
   generate
      for (i = 0; i < SOURCES; i++) begin : g_src
         logic be_bit;
         if (i < pic_pkg::BE_W) begin : g_be
            assign be_bit = both_edge_ff[i];
         end else begin : g_nobe
            assign be_bit = 1'b0;
         end

         pic_cell #(
            .IS_EXT (i < EXT_LINES)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .sel       (req_accept && (req_src_index == pic_pkg::SRC_W'(i))),
            .op        (op),
            .both_edge (be_bit),
            .cb        (cb[i])
         );

         // posting level: zero unless the request flag is set
         assign post[i].lvl = cb[i][pic_pkg::REQ_BIT] ? cb[i][pic_pkg::LVL_W-1:0] : '0;
         assign post[i].idx = pic_pkg::SRC_W'(i);
      end
   endgenerate

   // read mux, out-of-range sources read as zero
   always_comb begin
      rd_byte = '0;
      for (int k = 0; k < SOURCES; k++) begin
         if (req_src_index == pic_pkg::SRC_W'(k)) begin
            rd_byte = cb[k];
         end
      end
   end

   // tree sees the state left by the command in the middle stage, since the
   // next command can only update the cells at the same edge the middle
   // stage drains
   pic_prio #(
      .SOURCES (SOURCES)
   ) u_prio (
      .leaf (post),
      .win  (win)
   );

   always_comb begin
      both_edge_in = csr_write_enable ? csr_write_data : both_edge_ff;

      mid_valid_in = req_accept || (mid_valid_ff && !out_load);
      mid_rd_in    = mid_rd_ff;
      if (req_accept) begin
         mid_rd_in = (op.cmd == pic_pkg::CMD_READ) ? rd_byte : '0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_rd_in    = rsp_rd_ff;
      rsp_win_in   = rsp_win_ff;
      if (out_load) begin
         rsp_valid_in = mid_valid_ff;
         if (mid_valid_ff) begin
            rsp_rd_in  = mid_rd_ff;
            rsp_win_in = win;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         both_edge_ff <= '0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         both_edge_ff <= both_edge_in;
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mid_rd_ff  <= mid_rd_in;
      rsp_rd_ff  <= rsp_rd_in;
      rsp_win_ff <= rsp_win_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_rd_ff;
   assign rsp_irq_level   = rsp_win_ff.lvl;
   assign rsp_irq_number  = rsp_win_ff.idx;
   assign rsp_irq_pending = (rsp_win_ff.lvl != '0);

endmodule

`default_nettype wire

// ===== rtl/pic_checker.sv =====
`default_nettype none

module pic_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire logic [pic_pkg::CB_W-1:0]  rsp_read_data,
   input wire logic                      rsp_irq_pending,
   input wire logic [pic_pkg::LVL_W-1:0] rsp_irq_level,
   input wire logic [pic_pkg::SRC_W-1:0] rsp_irq_number
);

   // pipeline empties at reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response valid or request stall after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data) &&
         $stable(rsp_irq_level) && $stable(rsp_irq_number))
      else $error("stalled response changed");

   // pending flag agrees with the reported level
   a_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_irq_pending == (rsp_irq_level != '0)))
      else $error("pending flag disagrees with level");

   // no winner reports source zero
   a_idle_number: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_irq_pending |-> (rsp_irq_number == '0))
      else $error("source number without a pending interrupt");

   // request side stalls only while a response waits
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with a free response stage");

endmodule

bind priority_interrupt_controller pic_checker u_pic_checker (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // generous bound: ~800 commands under idling and stalls
   localparam int unsigned CYCLE_LIMIT = 200_000;
   localparam int          PHASE_ITEMS = 190;

   // shadow of the controller: control bytes, stored lines and both-edge bits,
   // plus the queue of status words still owed by the response channel
   class irq_tracker;
      localparam int NUM_SRC   = 64;
      localparam int EXT_LINES = 6;

      typedef struct {
         logic [pic_pkg::CB_W-1:0]  read_data;
         logic                      pending;
         logic [pic_pkg::LVL_W-1:0] level;
         logic [pic_pkg::SRC_W-1:0] number;
      } status_type;

      logic [pic_pkg::CB_W-1:0] ctrl_byte [NUM_SRC];
      logic                     line_hi   [NUM_SRC];
      logic [pic_pkg::BE_W-1:0] edge_sel;
      status_type               owed_status [$];
      int                       errors;

      function new();
         for (int i = 0; i < NUM_SRC; i++) begin
            ctrl_byte[i] = '0;
            line_hi[i]   = 1'b1;
         end
         edge_sel = '0;
         errors   = 0;
      endfunction

      function void set_both_edge(logic [pic_pkg::BE_W-1:0] value);
         edge_sel = value;
      endfunction

      function int outstanding();
         return owed_status.size();
      endfunction

      // level-sensed line: request follows line == polarity
      function void resample(int s);
         ctrl_byte[s][pic_pkg::REQ_BIT] = (line_hi[s] == ctrl_byte[s][pic_pkg::POL_BIT]);
      endfunction

      function void line_event(int s, logic lvl);
         logic                     was_hi;
         logic [pic_pkg::CB_W-1:0] cb;
         was_hi     = line_hi[s];
         cb         = ctrl_byte[s];
         line_hi[s] = lvl;
         if (s >= EXT_LINES) begin
            // ordinary source: falling edge only
            if (was_hi && !lvl) ctrl_byte[s][pic_pkg::REQ_BIT] = 1'b1;
         end else if (cb[pic_pkg::LVS_BIT]) begin
            resample(s);
         end else if (was_hi != lvl && !cb[pic_pkg::REQ_BIT]) begin
            if (edge_sel[s])
               ctrl_byte[s][pic_pkg::REQ_BIT] = 1'b1;
            else if (cb[pic_pkg::POL_BIT] == lvl)
               ctrl_byte[s][pic_pkg::REQ_BIT] = 1'b1;
         end
      endfunction

      // apply one accepted command and queue the status it must produce
      function void apply_command(pic_pkg::cmd_type cmd, logic [pic_pkg::SRC_W-1:0] src,
                                  logic [pic_pkg::CB_W-1:0] data, logic lvl);
         status_type                st;
         logic [pic_pkg::CB_W-1:0]  cb;
         logic [pic_pkg::LVL_W-1:0] best;
         logic [pic_pkg::SRC_W-1:0] who;
         cb   = ctrl_byte[src];
         st.read_data = '0;
         case (cmd)
            pic_pkg::CMD_READ: begin
               st.read_data = cb;
            end
            pic_pkg::CMD_WRITE: begin
               // the write itself never raises the request bit; level sense may resample it
               ctrl_byte[src] = (cb & data & pic_pkg::REQ_MASK) |
                                (data & ~pic_pkg::REQ_MASK);
               if (src < EXT_LINES && data[pic_pkg::LVS_BIT]) resample(int'(src));
            end
            pic_pkg::CMD_ACK: begin
               ctrl_byte[src][pic_pkg::REQ_BIT] = 1'b0;
            end
            default: begin
               line_event(int'(src), lvl);
            end
         endcase
         best = '0;
         who  = '0;
         for (int i = 0; i < NUM_SRC; i++) begin
            if (ctrl_byte[i][pic_pkg::REQ_BIT] &&
                ctrl_byte[i][pic_pkg::LVL_W-1:0] > best) begin
               best = ctrl_byte[i][pic_pkg::LVL_W-1:0];
               who  = pic_pkg::SRC_W'(i);
            end
         end
         st.pending = (best != '0);
         st.level   = best;
         st.number  = who;
         owed_status.push_back(st);
      endfunction

      task report(string msg);
         errors++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task check_status(logic [pic_pkg::CB_W-1:0] rd, logic pend,
                        logic [pic_pkg::LVL_W-1:0] lvl, logic [pic_pkg::SRC_W-1:0] num);
         status_type st;
         if (owed_status.size() == 0) begin
            report("response transfer with no command outstanding");
         end else begin
            st = owed_status.pop_front();
            if (rd !== st.read_data)
               report($sformatf("read_data %h, expected %h", rd, st.read_data));
            if (pend !== st.pending)
               report($sformatf("irq_pending %b, expected %b", pend, st.pending));
            if (lvl !== st.level)
               report($sformatf("irq_level %0d, expected %0d", lvl, st.level));
            if (num !== st.number)
               report($sformatf("irq_number %0d, expected %0d", num, st.number));
         end
      endtask

      task drain_check();
         if (owed_status.size() != 0)
            report($sformatf("%0d responses never arrived", owed_status.size()));
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_write_enable;
   logic [pic_pkg::BE_W-1:0]  csr_write_data;
   logic                      req_valid;
   logic                      req_stall;
   logic [1:0]                req_cmd;
   logic [pic_pkg::SRC_W-1:0] req_src_index;
   logic [pic_pkg::CB_W-1:0]  req_wdata;
   logic                      req_line_level;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [pic_pkg::CB_W-1:0]  rsp_read_data;
   logic                      rsp_irq_pending;
   logic [pic_pkg::LVL_W-1:0] rsp_irq_level;
   logic [pic_pkg::SRC_W-1:0] rsp_irq_number;

   irq_tracker  tracker;
   int unsigned cycles = 0;
   int          idle_pct;    // chance of a gap before each request transfer
   int          stall_pct;   // chance of stalling the response side per cycle

   priority_interrupt_controller dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_src_index    (req_src_index),
      .req_wdata        (req_wdata),
      .req_line_level   (req_line_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_irq_pending  (rsp_irq_pending),
      .rsp_irq_level    (rsp_irq_level),
      .rsp_irq_number   (rsp_irq_number)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side back-pressure, changed on the falling edge only
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // sample at the rising edge: check every response transfer, watch the clock
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_status(rsp_read_data, rsp_irq_pending, rsp_irq_level,
                              rsp_irq_number);
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         tracker.report($sformatf("run not finished after %0d cycles", cycles));
         $display("** priority_interrupt_controller: FAILED **");
         $finish;
      end
   end

   // one request transfer; entered and left at a falling edge
   task automatic send_cmd(input pic_pkg::cmd_type cmd,
                           input logic [pic_pkg::SRC_W-1:0] src,
                           input logic [pic_pkg::CB_W-1:0] data, input logic lvl);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         req_wdata <= pic_pkg::CB_W'($urandom);
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_src_index  <= src;
      req_wdata      <= data;
      req_line_level <= lvl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.apply_command(cmd, src, data, lvl);
      @(negedge clock);
   endtask

   // drop valid and let the pipeline empty before touching the csr
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_both_edge(input logic [pic_pkg::BE_W-1:0] value);
      wait_quiet();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      tracker.set_both_edge(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data   <= pic_pkg::BE_W'($urandom);
      @(negedge clock);
   endtask

   // random command biased toward the external lines, where most behavior lives
   task automatic send_random();
      int                        pick;
      pic_pkg::cmd_type          cmd;
      logic [pic_pkg::SRC_W-1:0] src;
      pick = $urandom_range(99);
      if (pick < 40)      cmd = pic_pkg::CMD_LINE;
      else if (pick < 65) cmd = pic_pkg::CMD_WRITE;
      else if (pick < 80) cmd = pic_pkg::CMD_ACK;
      else                cmd = pic_pkg::CMD_READ;
      pick = $urandom_range(9);
      if (pick < 5)       src = pic_pkg::SRC_W'($urandom_range(5));
      else if (pick == 5) src = pic_pkg::SRC_W'($urandom_range(7, 6));
      else                src = pic_pkg::SRC_W'($urandom_range(63));
      send_cmd(cmd, src, pic_pkg::CB_W'($urandom), 1'($urandom));
   endtask

   initial begin
      tracker          = new();
      idle_pct         = 15;
      stall_pct        = 15;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_valid        <= 1'b0;
      req_cmd          <= pic_pkg::CMD_READ;
      req_src_index    <= '0;
      req_wdata        <= '0;
      req_line_level   <= 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, both-edge bits at reset value
      send_cmd(pic_pkg::CMD_READ,  6'd0,  8'h00, 1'b0);   // reset value of a control byte
      send_cmd(pic_pkg::CMD_WRITE, 6'd63, 8'hFF, 1'b1);   // write cannot raise the request
      send_cmd(pic_pkg::CMD_READ,  6'd63, 8'h00, 1'b0);   // upper bits read back
      send_cmd(pic_pkg::CMD_LINE,  6'd63, 8'h00, 1'b0);   // ordinary falling edge posts
      send_cmd(pic_pkg::CMD_ACK,   6'd63, 8'h00, 1'b0);
      send_cmd(pic_pkg::CMD_LINE,  6'd63, 8'h00, 1'b0);   // same level again is no edge
      send_cmd(pic_pkg::CMD_WRITE, 6'd10, 8'h05, 1'b0);
      send_cmd(pic_pkg::CMD_LINE,  6'd10, 8'h00, 1'b0);
      send_cmd(pic_pkg::CMD_WRITE, 6'd20, 8'h05, 1'b0);
      send_cmd(pic_pkg::CMD_LINE,  6'd20, 8'h00, 1'b0);   // tie goes to the lower index
      send_cmd(pic_pkg::CMD_WRITE, 6'd10, 8'h00, 1'b0);   // write clears request
      send_cmd(pic_pkg::CMD_LINE,  6'd30, 8'h00, 1'b0);   // level zero requests never post
      send_cmd(pic_pkg::CMD_WRITE, 6'd0,  8'h03, 1'b0);   // external, edge mode, active low
      send_cmd(pic_pkg::CMD_LINE,  6'd0,  8'h00, 1'b1);
      send_cmd(pic_pkg::CMD_ACK,   6'd0,  8'h00, 1'b0);
      send_cmd(pic_pkg::CMD_LINE,  6'd0,  8'h00, 1'b1);   // line stays high: no edge, and the wrong level for polarity
      send_cmd(pic_pkg::CMD_WRITE, 6'd1,  8'h14, 1'b0);   // active high edge
      send_cmd(pic_pkg::CMD_LINE,  6'd1,  8'h00, 1'b0);
      send_cmd(pic_pkg::CMD_LINE,  6'd1,  8'h00, 1'b1);
      send_cmd(pic_pkg::CMD_WRITE, 6'd2,  8'h36, 1'b0);   // level sense resamples on write
      send_cmd(pic_pkg::CMD_LINE,  6'd2,  8'h00, 1'b0);   // level drop clears request

      write_both_edge(6'h3F);
      send_cmd(pic_pkg::CMD_WRITE, 6'd3,  8'h07, 1'b0);
      send_cmd(pic_pkg::CMD_LINE,  6'd3,  8'h00, 1'b0);
      send_cmd(pic_pkg::CMD_ACK,   6'd3,  8'h00, 1'b0);
      send_cmd(pic_pkg::CMD_LINE,  6'd3,  8'h00, 1'b1);   // both-edge: rising also sets
      send_cmd(pic_pkg::CMD_WRITE, 6'd3,  8'h0F, 1'b0);   // request kept when bit written 1

      // random phases over several both-edge settings
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       write_both_edge(6'h00);
            1:       write_both_edge(6'h3F);
            default: write_both_edge(pic_pkg::BE_W'($urandom));
         endcase
         // one whole phase runs flat out on both sides
         idle_pct  = (phase == 2) ? 0 : 15;
         stall_pct = (phase == 2) ? 0 : 15;
         for (int n = 0; n < PHASE_ITEMS; n++) send_random();
      end

      wait_quiet();
      repeat (8) @(negedge clock);
      tracker.drain_check();
      if (tracker.errors == 0)
         $display("** priority_interrupt_controller: PASSED **");
      else
         $display("** priority_interrupt_controller: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/pic_pkg.sv
rtl/pic_cell.sv
rtl/pic_prio.sv
rtl/priority_interrupt_controller.sv
rtl/pic_checker.sv
tb/sv/testbench.sv
